[rtl/core/downlink_frame_checker_assert.svh]
// Assertion macros shared by the frame checker RTL
`ifndef DOWNLINK_FRAME_CHECKER_ASSERT_SVH
`define DOWNLINK_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define DFC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dfc_pkg.sv]
// Shared types and constants of the downlink frame checker
`timescale 1ns / 1ps

package dfc_pkg;

   // frame limits
   localparam int unsigned MAX_FRAME_BYTES = 255;
   localparam logic [8:0]  MAX_FRAME_POS   = 9'(MAX_FRAME_BYTES);
   localparam logic [8:0]  POS_SATURATE    = 9'd511;
   localparam logic [8:0]  LAST_SHORT_POS  = 9'd12;

   // message types that get checked
   localparam logic [2:0]  TYPE_UNCONF_DOWN = 3'd3;
   localparam logic [2:0]  TYPE_CONF_DOWN   = 3'd5;

   // reset value of the device address register
   localparam logic [31:0] ADDR_RESET = 32'h4455_6677;

   // result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = QPTR_W + 1;

   // result item kind
   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_IGNORED    = 3'd0,
      ST_ACCEPTED   = 3'd1,
      ST_SHORT      = 3'd2,
      ST_BAD_CHECK  = 3'd3,
      ST_WRONG_ADDR = 3'd4,
      ST_PORT_ZERO  = 3'd5,
      ST_TOO_LONG   = 3'd6
   } dfc_status_type;

   typedef struct packed {
      logic           item_kind;
      logic [7:0]     payload_byte;
      dfc_status_type frame_status;
      logic           ack_request;
      logic [7:0]     payload_length;
      logic           last_result;
   } dfc_item_type;

   // results of one accepted byte: payload item first, then status item
   typedef struct packed {
      logic         pay_valid;
      logic         stat_valid;
      dfc_item_type pay;
      dfc_item_type stat;
   } dfc_push_type;

endpackage

[rtl/core/downlink_frame_checker.sv]
// Top level of the downlink frame checker
// Takes one frame byte per cycle unless stalled and returns one result beat per
// cycle unless stalled. A byte produces at most one payload beat, and a byte marked
// last adds a closing status beat, so the result side carries one more beat per
// frame. Results pass through a four-entry queue; the byte side stalls while
// fewer than two entries are free, so it runs at one byte per cycle as long as
// results are taken at that rate. Payload beats are tentative: any status other
// than accepted means the frame's payload must be dropped. The device address
// register may only be written while no frame is in flight.
`timescale 1ns / 1ps

module downlink_frame_checker (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_frame_status,
   output logic        rsp_ack_request,
   output logic [7:0]  rsp_payload_length,
   output logic        rsp_last_result,
   // device address register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_device_address
);
   import dfc_pkg::*;

   logic [31:0]  dev_addr_ff, dev_addr_in;
   logic         req_accept;
   logic         rsp_accept;
   logic         queue_full;
   dfc_push_type push;
   dfc_item_type head;

   // device address register
   assign csr_ready = 1'b1;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (csr_valid && csr_ready) begin
         dev_addr_in = csr_device_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   // handshakes
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   dfc_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .beat_accept    (req_accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .device_address (dev_addr_ff),
      .push           (push)
   );

   dfc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .head      (head),
      .not_empty (rsp_valid),
      .no_room   (queue_full)
   );

   // result fields
   assign rsp_item_kind      = head.item_kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_frame_status   = head.frame_status;
   assign rsp_ack_request    = head.ack_request;
   assign rsp_payload_length = head.payload_length;
   assign rsp_last_result    = head.last_result;

endmodule

[rtl/core/dfc_parser.sv]
// Per-byte frame parsing, check logic and result generation
`timescale 1ns / 1ps
`include "downlink_frame_checker_assert.svh"

module dfc_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic [31:0]         device_address,
   output dfc_pkg::dfc_push_type push
);
   import dfc_pkg::*;

   // frame state
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  tail_ff [4];
   logic [7:0]  tail_in [4];
   logic [2:0]  type_ff, type_in;
   logic [31:0] addr_ff, addr_in;
   logic [3:0]  opts_ff, opts_in;
   logic [7:0]  port_ff, port_in;
   logic [7:0]  cnt_ff, cnt_in;

   // values as updated by the current byte
   logic [2:0]     type_eff;
   logic [31:0]    addr_eff;
   logic [3:0]     opts_eff;
   logic [7:0]     port_eff;
   logic [7:0]     sum_eff;
   logic [7:0]     cnt_eff;
   logic           checked;
   logic           past_head;
   logic           emit;
   logic           has_payload;
   dfc_status_type status;
   logic           ack;
   logic [7:0]     plen;

   // field capture and payload decision
   always_comb begin
      type_eff = (pos_ff == 9'd0) ? data_byte[7:5] : type_ff;
      addr_eff = addr_ff;
      case (pos_ff)
         9'd1:    addr_eff[7:0]   = data_byte;
         9'd2:    addr_eff[15:8]  = data_byte;
         9'd3:    addr_eff[23:16] = data_byte;
         9'd4:    addr_eff[31:24] = data_byte;
         default: addr_eff        = addr_ff;
      endcase
      opts_eff = (pos_ff == 9'd5) ? data_byte[3:0] : opts_ff;
      port_eff = (pos_ff >= 9'd6 && pos_ff == 9'd8 + {5'd0, opts_eff}) ? data_byte : port_ff;
      checked  = (type_eff == TYPE_UNCONF_DOWN) || (type_eff == TYPE_CONF_DOWN);
      past_head = pos_ff >= 9'd4;
      sum_eff  = past_head ? sum_ff + tail_ff[0] : sum_ff;
      emit     = past_head && checked && (port_eff != 8'd0) &&
                 (pos_ff >= 9'd13 + {5'd0, opts_eff}) && (pos_ff < MAX_FRAME_POS);
      cnt_eff  = (emit && cnt_ff != 8'hFF) ? cnt_ff + 8'd1 : cnt_ff;
      has_payload = pos_ff > LAST_SHORT_POS + {5'd0, opts_eff};
   end

   // end-of-frame status, checks in priority order
   always_comb begin
      ack  = 1'b0;
      plen = 8'd0;
      if (pos_ff >= MAX_FRAME_POS) begin
         status = ST_TOO_LONG;
      end else if (!checked) begin
         status = ST_IGNORED;
      end else if (pos_ff < LAST_SHORT_POS) begin
         status = ST_SHORT;
      end else if (tail_ff[1] != 8'd0 || tail_ff[2] != 8'd0 || tail_ff[3] != 8'd0 ||
                   data_byte != sum_eff) begin
         status = ST_BAD_CHECK;
      end else if (addr_eff != device_address) begin
         status = ST_WRONG_ADDR;
      end else if (has_payload && port_eff == 8'd0 && opts_eff == 4'd0) begin
         status = ST_PORT_ZERO;
      end else begin
         status = ST_ACCEPTED;
         ack    = (type_eff == TYPE_CONF_DOWN);
         if (has_payload && port_eff != 8'd0) begin
            plen = cnt_eff;
         end
      end
   end

   // result items for this beat
   always_comb begin
      push.pay_valid           = beat_accept && emit;
      push.stat_valid          = beat_accept && last_byte;
      push.pay.item_kind       = ITEM_PAYLOAD;
      push.pay.payload_byte    = tail_ff[0];
      push.pay.frame_status    = ST_IGNORED;
      push.pay.ack_request     = 1'b0;
      push.pay.payload_length  = 8'd0;
      push.pay.last_result     = 1'b0;
      push.stat.item_kind      = ITEM_STATUS;
      push.stat.payload_byte   = 8'd0;
      push.stat.frame_status   = status;
      push.stat.ack_request    = ack;
      push.stat.payload_length = plen;
      push.stat.last_result    = 1'b1;
   end

   // next state: advance on each beat, clear after the last byte
   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      tail_in = tail_ff;
      type_in = type_ff;
      addr_in = addr_ff;
      opts_in = opts_ff;
      port_in = port_ff;
      cnt_in  = cnt_ff;
      if (beat_accept) begin
         if (last_byte) begin
            pos_in  = 9'd0;
            sum_in  = 8'd0;
            tail_in = '{default: 8'd0};
            type_in = 3'd0;
            addr_in = 32'd0;
            opts_in = 4'd0;
            port_in = 8'd0;
            cnt_in  = 8'd0;
         end else begin
            pos_in     = (pos_ff != POS_SATURATE) ? pos_ff + 9'd1 : pos_ff;
            sum_in     = sum_eff;
            tail_in[0] = tail_ff[1];
            tail_in[1] = tail_ff[2];
            tail_in[2] = tail_ff[3];
            tail_in[3] = data_byte;
            type_in    = type_eff;
            addr_in    = addr_eff;
            opts_in    = opts_eff;
            port_in    = port_eff;
            cnt_in     = cnt_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 9'd0;
         sum_ff  <= 8'd0;
         tail_ff <= '{default: 8'd0};
         type_ff <= 3'd0;
         addr_ff <= 32'd0;
         opts_ff <= 4'd0;
         port_ff <= 8'd0;
         cnt_ff  <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         tail_ff <= tail_in;
         type_ff <= type_in;
         addr_ff <= addr_in;
         opts_ff <= opts_in;
         port_ff <= port_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload never comes from the header or past the length limit
   `DFC_ASSERT_IMPL(a_pay_in_range, push.pay_valid, pos_ff >= 9'd4 && pos_ff < MAX_FRAME_POS, "payload beat outside frame body")
   // a closing byte leaves the frame state cleared
   `DFC_ASSERT_NEXT(a_clear_after_last, beat_accept && last_byte, pos_ff == 9'd0 && cnt_ff == 8'd0 && sum_ff == 8'd0, "frame state not cleared")

endmodule

[rtl/core/dfc_rsp_queue.sv]
// Four-entry result queue taking up to two items per cycle
`timescale 1ns / 1ps
`include "downlink_frame_checker_assert.svh"

module dfc_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dfc_pkg::dfc_push_type push,
   input  logic                  pop,
   output dfc_pkg::dfc_item_type head,
   output logic                  not_empty,
   output logic                  no_room
);
   import dfc_pkg::*;

   dfc_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QCNT_W-1:0]   push_n;
   dfc_item_type        first_item;

   // payload item goes ahead of the status item of the same byte
   always_comb begin
      push_n     = QCNT_W'(push.pay_valid) + QCNT_W'(push.stat_valid);
      first_item = push.pay_valid ? push.pay : push.stat;
      wr_ptr_in  = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in  = rd_ptr_ff + QPTR_W'(pop);
      count_in   = count_ff + push_n - QCNT_W'(pop);
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign no_room   = count_ff > QCNT_W'(QUEUE_DEPTH - 2);

   // entry storage
   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         slot_ff[wr_ptr_ff] <= first_item;
      end
      if (push.pay_valid && push.stat_valid) begin
         slot_ff[wr_ptr_ff + QPTR_W'(1)] <= push.stat;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // a push only lands while two entries are free
   `DFC_ASSERT_IMPL(a_no_overrun, push_n != '0, count_ff <= QCNT_W'(QUEUE_DEPTH - 2), "result queue overrun")
   // pointer distance agrees with the fill count
   `DFC_ASSERT_IMPL(a_ptr_count, 1'b1, count_ff[QPTR_W-1:0] == QPTR_W'(wr_ptr_ff - rd_ptr_ff), "queue pointers and count disagree")

endmodule
